### rtl/bmmd_pkg.sv
// ----------------------------------------------------------------------------
// bmmd_pkg
// Types and constants shared by the banked memory map decoder modules.
// ----------------------------------------------------------------------------
package bmmd_pkg;

    // machine models
    localparam logic [1:0] MODEL_FIRST  = 2'd0;
    localparam logic [1:0] MODEL_SECOND = 2'd1;
    localparam logic [1:0] MODEL_THIRD  = 2'd2;

    // request types
    localparam logic [1:0] REQ_MEM_RD = 2'd0;
    localparam logic [1:0] REQ_MEM_WR = 2'd1;
    localparam logic [1:0] REQ_IO_RD  = 2'd2;
    localparam logic [1:0] REQ_IO_WR  = 2'd3;

    // targets
    localparam logic [3:0] T_NONE     = 4'd0;
    localparam logic [3:0] T_ROM      = 4'd1;
    localparam logic [3:0] T_MONRAM   = 4'd2;
    localparam logic [3:0] T_LOWBANK  = 4'd3;
    localparam logic [3:0] T_USER     = 4'd4;
    localparam logic [3:0] T_HIGHBANK = 4'd5;
    localparam logic [3:0] T_VRAM     = 4'd6;
    localparam logic [3:0] T_PPI      = 4'd7;
    localparam logic [3:0] T_TIMER    = 4'd8;
    localparam logic [3:0] T_SPEAKER  = 4'd9;
    localparam logic [3:0] T_FIXED    = 4'd10;

    // video mode events
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_NORMAL  = 2'd1;
    localparam logic [1:0] EV_REVERSE = 2'd2;

    // address map
    localparam logic [15:0] ADDR_USER_BASE = 16'h1000;
    localparam logic [15:0] ADDR_HIGH_BASE = 16'hD000;
    localparam logic [15:0] ADDR_VRAM_TOP2 = 16'hD800;
    localparam logic [15:0] ADDR_PPI_BASE  = 16'hE000;
    localparam logic [15:0] ADDR_TMR_BASE  = 16'hE004;
    localparam logic [15:0] ADDR_SPEAKER   = 16'hE008;
    localparam logic [15:0] ADDR_VID_NORM  = 16'hE014;
    localparam logic [15:0] ADDR_VID_REV   = 16'hE015;
    localparam logic [7:0]  ADDR_SCROLL_HI = 8'hE2;
    localparam logic [15:0] VRAM_MASK_1K   = 16'h03FF;
    localparam logic [15:0] VRAM_MASK_2K   = 16'h07FF;

    // fixed read values
    localparam logic [7:0] FIXED_UNUSED = 8'hC7;
    localparam logic [7:0] FIXED_IO     = 8'h00;
    localparam logic [7:0] FIXED_NORMAL = 8'h00;
    localparam logic [7:0] FIXED_REV    = 8'hFF;

    // bank control ports
    localparam logic [7:0] PORT_LOW_ON   = 8'hE0;
    localparam logic [7:0] PORT_HIGH_ON  = 8'hE1;
    localparam logic [7:0] PORT_LOW_OFF  = 8'hE2;
    localparam logic [7:0] PORT_HIGH_OFF = 8'hE3;
    localparam logic [7:0] PORT_RESET    = 8'hE4;
    localparam logic [7:0] PORT_LOCK     = 8'hE5;
    localparam logic [7:0] PORT_UNLOCK   = 8'hE6;

    typedef struct packed {
        logic low_on;
        logic high_on;
        logic locked;
    } t_bank_state;

    typedef struct packed {
        logic [3:0]  target;
        logic [15:0] offset;
        logic        is_write;
        logic [7:0]  data;
        logic [1:0]  event_code;
    } t_result;

endpackage

### rtl/bmmd_bank_ctl.sv
// ----------------------------------------------------------------------------
// bmmd_bank_ctl
// Bank switch and high-area lock state, driven by I/O writes on the third model.
// ----------------------------------------------------------------------------
module bmmd_bank_ctl
    import bmmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_update,
    input  logic [1:0]  i_model,
    input  logic [7:0]  i_port,
    output t_bank_state o_state
);

    t_bank_state r_state;
    t_bank_state n_state;

    always_comb begin
        n_state = r_state;
        if (i_update && i_model == MODEL_THIRD) begin
            case (i_port)
                PORT_LOW_ON:   n_state.low_on  = 1'b1;
                PORT_HIGH_ON:  n_state.high_on = 1'b1;
                PORT_LOW_OFF:  n_state.low_on  = 1'b0;
                PORT_HIGH_OFF: n_state.high_on = 1'b0;
                PORT_RESET:    n_state = '0;
                PORT_LOCK:     n_state.locked  = 1'b1;
                PORT_UNLOCK:   n_state.locked  = 1'b0;
                default:       n_state = r_state;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

    a_reset_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_update && i_model == MODEL_THIRD && i_port == PORT_RESET) |=> (r_state == '0))
        else $error("bank reset port did not clear bank state");

    a_other_model_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_model != MODEL_THIRD) |=> $stable(r_state))
        else $error("bank state changed outside the third model");

endmodule

### rtl/bmmd_decode.sv
// ----------------------------------------------------------------------------
// bmmd_decode
// Maps one bus request to a target, offset, data byte and video mode event.
// ----------------------------------------------------------------------------
module bmmd_decode
    import bmmd_pkg::*;
(
    input  logic [1:0]  i_model,
    input  t_bank_state i_bank,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_data,
    output t_result     o_result
);

    function automatic t_result mk(input logic [3:0] tgt, input logic [15:0] off,
                                   input logic wr, input logic [7:0] dat,
                                   input logic [1:0] ev);
        t_result res;
        res.target     = tgt;
        res.offset     = off;
        res.is_write   = wr;
        res.data       = dat;
        res.event_code = ev;
        return res;
    endfunction

    logic        wr;
    logic [7:0]  wd;
    logic [15:0] a;
    logic        m2;
    logic        m3;
    t_result     res_none;
    t_result     res_unused;

    assign a  = i_bus_address;
    assign wr = (i_req_type == REQ_MEM_WR);
    assign wd = wr ? i_write_data : 8'h00;
    assign m2 = (i_model == MODEL_SECOND);
    assign m3 = (i_model == MODEL_THIRD);
    assign res_none   = mk(T_NONE, 16'h0000, 1'b0, 8'h00, EV_NONE);
    assign res_unused = mk(T_FIXED, 16'h0000, 1'b0, FIXED_UNUSED, EV_NONE);

    always_comb begin
        o_result = res_none;
        case (i_req_type)
            REQ_IO_RD: o_result = mk(T_FIXED, 16'h0000, 1'b0, FIXED_IO, EV_NONE);
            REQ_IO_WR: o_result = res_none;
            REQ_MEM_RD, REQ_MEM_WR: begin
                if (a < ADDR_USER_BASE) begin
                    if (m2) begin
                        o_result = mk(T_MONRAM, a, wr, wd, EV_NONE);
                    end else if (m3 && i_bank.low_on) begin
                        o_result = mk(T_LOWBANK, a, wr, wd, EV_NONE);
                    end else if (wr) begin
                        o_result = res_none;
                    end else begin
                        o_result = mk(T_ROM, a, 1'b0, 8'h00, EV_NONE);
                    end
                end else if (a < ADDR_HIGH_BASE) begin
                    o_result = mk(T_USER, a - ADDR_USER_BASE, wr, wd, EV_NONE);
                end else if (m3 && i_bank.locked) begin
                    o_result = wr ? res_none : res_unused;
                end else if (m3 && i_bank.high_on) begin
                    o_result = mk(T_HIGHBANK, a - ADDR_HIGH_BASE, wr, wd, EV_NONE);
                end else if (a < ADDR_PPI_BASE) begin
                    if (m3) begin
                        o_result = mk(T_VRAM, a - ADDR_HIGH_BASE, wr, wd, EV_NONE);
                    end else if (m2) begin
                        if (a < ADDR_VRAM_TOP2) begin
                            o_result = mk(T_VRAM, a & VRAM_MASK_2K, wr, wd, EV_NONE);
                        end else begin
                            o_result = wr ? res_none : res_unused;
                        end
                    end else begin
                        o_result = mk(T_VRAM, a & VRAM_MASK_1K, wr, wd, EV_NONE);
                    end
                end else if (a < ADDR_TMR_BASE) begin
                    o_result = mk(T_PPI, a - ADDR_PPI_BASE, wr, wd, EV_NONE);
                end else if (a < ADDR_SPEAKER) begin
                    o_result = mk(T_TIMER, a - ADDR_TMR_BASE, wr, wd, EV_NONE);
                end else if (a == ADDR_SPEAKER) begin
                    o_result = mk(T_SPEAKER, 16'h0000, wr, wd, EV_NONE);
                end else if (wr) begin
                    o_result = res_none;
                end else if (m2 && a == ADDR_VID_NORM) begin
                    o_result = mk(T_FIXED, 16'h0000, 1'b0, FIXED_NORMAL, EV_NORMAL);
                end else if (m2 && a == ADDR_VID_REV) begin
                    o_result = mk(T_FIXED, 16'h0000, 1'b0, FIXED_REV, EV_REVERSE);
                end else if (m2 && a[15:8] == ADDR_SCROLL_HI) begin
                    // scroll registers read back their low address byte
                    o_result = mk(T_FIXED, 16'h0000, 1'b0, a[7:0], EV_NONE);
                end else begin
                    o_result = res_unused;
                end
            end
            default: o_result = res_none;
        endcase
    end

endmodule

### rtl/banked_memory_map_decoder.sv
// ----------------------------------------------------------------------------
// banked_memory_map_decoder
// Bus address decoder with three machine models and third-model bank switching.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_ready | i_req_type, i_bus_address, i_write_data
//  out     | output    | o_out_valid/i_out_ready | o_target, o_target_offset, o_is_write,
//          |           |                         | o_data_byte, o_video_mode_event
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (machine model)
//
//  One beat per cycle sustained unless the output stalls; input register, then decode
//  into the result register. Bank state updates as an I/O write leaves the input
//  register, so the next beat decodes with the new state.
//  Reset clears the model, bank state and both valid flags.
//  A stalled result register holds, and the input register fills behind it.
// ----------------------------------------------------------------------------
module banked_memory_map_decoder
    import bmmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_target,
    output logic [15:0] o_target_offset,
    output logic        o_is_write,
    output logic [7:0]  o_data_byte,
    output logic [1:0]  o_video_mode_event,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);

    logic [1:0]  r_model;
    logic        r_in_valid;
    logic [1:0]  r_req_type;
    logic [15:0] r_bus_address;
    logic [7:0]  r_write_data;
    logic        r_out_valid;
    t_result     r_out;

    logic        s1_advance;
    t_bank_state bank;
    t_result     dec;

    assign s1_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || s1_advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model     <= MODEL_FIRST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_model <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req_type    <= i_req_type;
            r_bus_address <= i_bus_address;
            r_write_data  <= i_write_data;
        end
        if (s1_advance) begin
            r_out <= dec;
        end
    end

    bmmd_bank_ctl u_bank_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (s1_advance && r_req_type == REQ_IO_WR),
        .i_model  (r_model),
        .i_port   (r_bus_address[7:0]),
        .o_state  (bank)
    );

    bmmd_decode u_decode (
        .i_model       (r_model),
        .i_bank        (bank),
        .i_req_type    (r_req_type),
        .i_bus_address (r_bus_address),
        .i_write_data  (r_write_data),
        .o_result      (dec)
    );

    assign o_out_valid        = r_out_valid;
    assign o_target           = r_out.target;
    assign o_target_offset    = r_out.offset;
    assign o_is_write         = r_out.is_write;
    assign o_data_byte        = r_out.data;
    assign o_video_mode_event = r_out.event_code;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("result register changed while stalled");

    a_none_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.target == T_NONE) |-> (!r_out.is_write && r_out.data == 8'h00))
        else $error("ignored access carries write or data");

    a_event_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_code != EV_NONE) |-> (r_out.target == T_FIXED))
        else $error("video mode event on a non-fixed target");

endmodule
